### hdl/sca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_pkg
// Shared constants, types and helpers for the sequencing check and
// adjacency tally block.
// ----------------------------------------------------------------------------
package sca_pkg;

   localparam int MAX_MODULUS = 16;
   localparam int COUNT_W     = 32;
   localparam int MOD_W       = $clog2(MAX_MODULUS + 1);
   localparam int ELEM_W      = $clog2(MAX_MODULUS);
   localparam int ADDR_W      = 2 * ELEM_W;
   localparam int ADJ_DEPTH   = MAX_MODULUS * MAX_MODULUS;
   localparam int BUF_DEPTH   = MAX_MODULUS - 1;

   localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(7);
   localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(3);
   localparam logic [MOD_W-1:0] MOD_MAX   = MOD_W'(MAX_MODULUS);

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_READ    = 5'b00100,
      ST_WALK_RD = 5'b01000,
      ST_WALK_WR = 5'b10000
   } state_type;

   typedef struct packed {
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [COUNT_W-1:0]  wr_data;
   } ram_req_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] x);
      logic [COUNT_W-1:0] r;
      r = (&x) ? x : x + COUNT_W'(1);
      return r;
   endfunction

endpackage

### hdl/sequencing_check_adjacency_tally.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequencing_check_adjacency_tally
// Checks candidate orderings of 1..v-1 for the sequencing property in Z_v
// and tallies adjacent pairs of valid orderings in a v by v count memory.
// Push request: result loaded at the accepting edge.
// Read request: the count memory read is registered, then ST_READ loads the
// response once the output is free. A push ending a valid ordering starts a
// read-modify-write walk over the count memory; no request is taken meanwhile.
// Synchronous reset; afterwards a clearing pass over all 256 entries zeroes
// the count memory while no request is taken (csr writes are always taken).
// ----------------------------------------------------------------------------
module sequencing_check_adjacency_tally (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // element[3:0], row[7:4], col[11:8]
   input  logic                            req_tuser,  // cmd
   input  logic                            req_tlast,  // last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [63:0]                     rsp_tdata,  // valid_total[31:0], adjacency_count[63:32]
   output logic [1:0]                      rsp_tuser,  // prefix_ok[0], ordering_valid[1]
   output logic                            rsp_tlast,  // done_res
   input  logic                            csr_wr_en,
   input  logic [sca_pkg::MOD_W-1:0]       csr_wr_data
);

   localparam int EW = sca_pkg::ELEM_W;
   localparam int MW = sca_pkg::MOD_W;
   localparam int CW = sca_pkg::COUNT_W;
   localparam int AW = sca_pkg::ADDR_W;

   sca_pkg::state_type   state_ff, state_in;
   logic [MW-1:0]        modulus_ff, modulus_in;
   logic [EW-1:0]        sum_ff, sum_in;
   logic [sca_pkg::MAX_MODULUS-1:0] seen_ff, seen_in;
   logic [sca_pkg::MAX_MODULUS-1:0] elem_map_ff, elem_map_in;
   logic                 still_ok_ff, still_ok_in;
   logic [MW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [EW-1:0]        walk_idx_ff, walk_idx_in;
   logic [EW-1:0]        walk_last_ff, walk_last_in;
   logic [EW-1:0]        prev_ff, prev_in;
   logic [AW-1:0]        rmw_addr_ff;
   logic                 rd_ok_ff;
   logic [EW-1:0]        buf_ff [0:sca_pkg::BUF_DEPTH-1];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_data_ff;
   logic [1:0]           rsp_user_ff;
   logic                 rsp_last_ff;

   sca_pkg::ram_req_type ram_req;
   logic [CW-1:0]        ram_rd_data;

   logic [MW-1:0]        v, vm1, elem_ext, sum_raw, sum_wrap, pos_next;
   logic [MW+2:0]        sum_ext, sum_m8, sum_m4, sum_m2;
   logic [EW-1:0]        element, row, col, sum_new, cur_elem;
   logic                 over_len, elem_bad, dup_elem, sum_hit, ok_push;
   logic                 end_valid, out_free, accept, push_acc, read_acc, load_read;
   logic [CW-1:0]        total_next;

   assign element = req_tdata[3:0];
   assign row     = req_tdata[7:4];
   assign col     = req_tdata[11:8];

   // effective modulus, clamped
   always_comb begin
      priority if (modulus_ff < sca_pkg::MOD_MIN) begin
         v = sca_pkg::MOD_MIN;
      end else if (modulus_ff > sca_pkg::MOD_MAX) begin
         v = sca_pkg::MOD_MAX;
      end else begin
         v = modulus_ff;
      end
   end
   assign vm1 = v - MW'(1);

   // push check
   assign elem_ext  = {1'b0, element};
   assign over_len  = pos_ff >= vm1;
   assign elem_bad  = (element == '0) || (elem_ext >= v);
   assign sum_raw   = {1'b0, sum_ff} + elem_ext;
   // running sum may exceed a reduced modulus, so reduce by 8v, 4v, 2v, v
   assign sum_ext   = {3'b000, sum_raw};
   assign sum_m8    = (sum_ext >= {v, 3'b000}) ? sum_ext - {v, 3'b000} : sum_ext;
   assign sum_m4    = (sum_m8 >= {1'b0, v, 2'b00}) ? sum_m8 - {1'b0, v, 2'b00} : sum_m8;
   assign sum_m2    = (sum_m4 >= {2'b00, v, 1'b0}) ? sum_m4 - {2'b00, v, 1'b0} : sum_m4;
   assign sum_wrap  = (sum_m2 >= {3'b000, v}) ? sum_m2[MW-1:0] - v : sum_m2[MW-1:0];
   assign sum_new   = sum_wrap[EW-1:0];
   assign dup_elem  = elem_map_ff[element];
   assign sum_hit   = (sum_new == '0) || seen_ff[sum_new];
   assign ok_push   = still_ok_ff && !over_len && !elem_bad && !dup_elem && !sum_hit;
   assign pos_next  = (pos_ff < sca_pkg::MOD_MAX) ? pos_ff + MW'(1) : pos_ff;
   assign end_valid = req_tlast && ok_push && (pos_next == vm1);
   assign total_next = end_valid ? sca_pkg::sat_inc(total_ff) : total_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == sca_pkg::ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign push_acc   = accept && (req_tuser == sca_pkg::CMD_PUSH);
   assign read_acc   = accept && (req_tuser == sca_pkg::CMD_READ);
   assign load_read  = (state_ff == sca_pkg::ST_READ) && out_free;
   assign cur_elem   = buf_ff[walk_idx_ff];

   // count memory requests
   always_comb begin
      ram_req = '0;
      if (read_acc) begin
         ram_req.rd_en   = 1'b1;
         ram_req.rd_addr = {row, col};
      end else if (state_ff == sca_pkg::ST_WALK_RD) begin
         ram_req.rd_en   = 1'b1;
         ram_req.rd_addr = {prev_ff, cur_elem};
      end
      if (state_ff == sca_pkg::ST_CLEAR) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = clr_cnt_ff;
         ram_req.wr_data = '0;
      end else if (state_ff == sca_pkg::ST_WALK_WR) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = rmw_addr_ff;
         ram_req.wr_data = sca_pkg::sat_inc(ram_rd_data);
      end
   end

   sca_adj_ram u_adj_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in     = state_ff;
      modulus_in   = csr_wr_en ? csr_wr_data : modulus_ff;
      sum_in       = sum_ff;
      seen_in      = seen_ff;
      elem_map_in  = elem_map_ff;
      still_ok_in  = still_ok_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      clr_cnt_in   = clr_cnt_ff;
      walk_idx_in  = walk_idx_ff;
      walk_last_in = walk_last_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         sca_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (&clr_cnt_ff) begin
               state_in = sca_pkg::ST_IDLE;
            end
         end
         sca_pkg::ST_IDLE: begin
            if (push_acc) begin
               rsp_valid_in = 1'b1;
               total_in     = total_next;
               if (req_tlast) begin
                  sum_in      = '0;
                  seen_in     = '0;
                  elem_map_in = '0;
                  still_ok_in = 1'b1;
                  pos_in      = '0;
                  if (end_valid) begin
                     state_in     = sca_pkg::ST_WALK_RD;
                     walk_idx_in  = '0;
                     prev_in      = '0;
                     walk_last_in = EW'(vm1 - MW'(1));
                  end
               end else begin
                  still_ok_in = ok_push;
                  pos_in      = pos_next;
                  if (!elem_bad) begin
                     sum_in                = sum_new;
                     seen_in[sum_new]      = 1'b1;
                     elem_map_in[element]  = 1'b1;
                  end
               end
            end else if (read_acc) begin
               state_in = sca_pkg::ST_READ;
            end
         end
         sca_pkg::ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = sca_pkg::ST_IDLE;
            end
         end
         sca_pkg::ST_WALK_RD: begin
            prev_in  = cur_elem;
            state_in = sca_pkg::ST_WALK_WR;
         end
         sca_pkg::ST_WALK_WR: begin
            walk_idx_in = walk_idx_ff + EW'(1);
            if (walk_idx_ff == walk_last_ff) begin
               state_in = sca_pkg::ST_IDLE;
            end else begin
               state_in = sca_pkg::ST_WALK_RD;
            end
         end
         default: begin
            state_in = sca_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sca_pkg::ST_CLEAR;
         modulus_ff   <= sca_pkg::MOD_RESET;
         sum_ff       <= '0;
         seen_ff      <= '0;
         elem_map_ff  <= '0;
         still_ok_ff  <= 1'b1;
         pos_ff       <= '0;
         total_ff     <= '0;
         clr_cnt_ff   <= '0;
         walk_idx_ff  <= '0;
         walk_last_ff <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         elem_map_ff  <= elem_map_in;
         still_ok_ff  <= still_ok_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         clr_cnt_ff   <= clr_cnt_in;
         walk_idx_ff  <= walk_idx_in;
         walk_last_ff <= walk_last_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (push_acc && !over_len) begin
         buf_ff[pos_ff[EW-1:0]] <= element;
      end
      if (read_acc) begin
         rd_ok_ff <= ({1'b0, row} < v) && ({1'b0, col} < v);
      end
      if (state_ff == sca_pkg::ST_WALK_RD) begin
         rmw_addr_ff <= {prev_ff, cur_elem};
      end
      if (push_acc) begin
         rsp_data_ff <= {{CW{1'b0}}, total_next};
         rsp_user_ff <= {end_valid, ok_push};
         rsp_last_ff <= req_tlast;
      end else if (load_read) begin
         rsp_data_ff <= {(rd_ok_ff ? ram_rd_data : {CW{1'b0}}), total_ff};
         rsp_user_ff <= {1'b0, still_ok_ff};
         rsp_last_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hdl/sca_adj_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_adj_ram
// Adjacency count memory: one write port and one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module sca_adj_ram (
   input  logic                          clock,
   input  sca_pkg::ram_req_type          req,
   output logic [sca_pkg::COUNT_W-1:0]   rd_data
);

   logic [sca_pkg::COUNT_W-1:0] mem_ff [0:sca_pkg::ADJ_DEPTH-1];
   logic [sca_pkg::COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks for the sequencing check block, bound to the top level.
// ----------------------------------------------------------------------------
module sca_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast
);

   // no response pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // clearing pass blocks requests right after reset
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // a valid ordering only on an ending push
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && rsp_tuser[0])
      else $error("ordering valid without end of ordering");

   // a valid ordering has been counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[31:0] != 32'd0)
      else $error("valid ordering with zero total");

endmodule

bind sequencing_check_adjacency_tally sca_checker u_sca_checker (.*);
